### rtl/ray_box_slab_intersection_macros.svh
// Assertion macros shared by the ray/box slab intersection RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECTION_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RBSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbsi check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RBSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbsi check failed");

`endif

### rtl/rbsi_pkg.sv
// Shared widths, constants and lane result types for the ray/box slab test.
// No dependencies; used by every RTL module of the block.
package rbsi_pkg;

    localparam int FIELD_W  = 32;  // signed Q16.16 coordinate
    localparam int EXT_W    = 31;  // unsigned Q15.16 box size
    localparam int FRAC_W   = 16;  // fraction bits
    localparam int DIFF_W   = 35;  // signed slab distance at twice the scale
    localparam int MAG_W    = 34;  // magnitude of a slab distance
    localparam int NUM_W    = MAG_W + FRAC_W;  // dividend width
    localparam int DEN_W    = FIELD_W + 1;     // magnitude of twice the direction
    localparam int T_W      = NUM_W + 1;       // signed crossing parameter
    localparam int MAX_AXES = 3;
    localparam int DIMS_DEF = 3;

    typedef struct packed {
        logic neg_lo;
        logic neg_hi;
        logic dir_zero;
        logic slab_miss;
    } t_side;

    typedef struct packed {
        logic                  limits;
        logic                  slab_miss;
        logic signed [T_W-1:0] t_lo;
        logic signed [T_W-1:0] t_hi;
    } t_lane_res;

endpackage

### rtl/rbsi_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Takes its default widths from rbsi_pkg; instantiated by rbsi_lane.
module rbsi_div #(
    parameter int NUM_W = rbsi_pkg::NUM_W,
    parameter int DEN_W = rbsi_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] s_num [NUM_W+1];
    logic [NUM_W-1:0] s_quo [NUM_W+1];
    logic [DEN_W-1:0] s_rem [NUM_W+1];
    logic [DEN_W-1:0] s_den [NUM_W+1];

    assign s_num[0] = i_num;
    assign s_quo[0] = '0;
    assign s_rem[0] = '0;
    assign s_den[0] = i_den;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [NUM_W-1:0] r_num;
        logic [NUM_W-1:0] r_quo;
        logic [DEN_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;

        // Bring down the next dividend bit and subtract if it fits.
        always_comb begin
            trial = {s_rem[k], s_num[k][NUM_W-1]};
            diff  = trial - {1'b0, s_den[k]};
            ge    = trial >= {1'b0, s_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num <= {s_num[k][NUM_W-2:0], 1'b0};
                r_quo <= {s_quo[k][NUM_W-2:0], ge};
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den <= s_den[k];
            end
        end

        assign s_num[k+1] = r_num;
        assign s_quo[k+1] = r_quo;
        assign s_rem[k+1] = r_rem;
        assign s_den[k+1] = r_den;
    end

    assign o_quo = s_quo[NUM_W];

endmodule

### rtl/rbsi_lane.sv
// One axis of the slab test: slab distances, two crossing divisions, ordering.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_origin,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_dir,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_center,
    input  logic        [rbsi_pkg::EXT_W-1:0]    i_extent,
    output rbsi_pkg::t_lane_res                  o_res
);

    localparam int FW = rbsi_pkg::FIELD_W;
    localparam int DW = rbsi_pkg::DIFF_W;
    localparam int MW = rbsi_pkg::MAG_W;
    localparam int NW = rbsi_pkg::NUM_W;
    localparam int EW = rbsi_pkg::DEN_W;
    localparam int TW = rbsi_pkg::T_W;

    logic signed [DW-1:0] o2, c2, sx, dlo, dhi, dlo_n, dhi_n;
    logic signed [FW:0]   dx, dx_n;
    logic        [FW:0]   dabs;
    rbsi_pkg::t_side      n_side;

    logic [NW-1:0]   r_num_lo, r_num_hi;
    logic [EW-1:0]   r_den;
    rbsi_pkg::t_side r_side [NW+1];
    logic [NW-1:0]   quo_lo, quo_hi;

    // Work at twice the scale so that half the box size stays exact.
    always_comb begin
        o2    = {{(DW-FW-1){i_origin[FW-1]}}, i_origin, 1'b0};
        c2    = {{(DW-FW-1){i_center[FW-1]}}, i_center, 1'b0};
        sx    = {{(DW-rbsi_pkg::EXT_W){1'b0}}, i_extent};
        dlo   = c2 - sx - o2;
        dhi   = c2 + sx - o2;
        dlo_n = -dlo;
        dhi_n = -dhi;
        dx    = {i_dir[FW-1], i_dir};
        dx_n  = -dx;
        dabs  = dx[FW] ? dx_n : dx;
        n_side.neg_lo    = dlo[DW-1] ^ i_dir[FW-1];
        n_side.neg_hi    = dhi[DW-1] ^ i_dir[FW-1];
        n_side.dir_zero  = (i_dir == '0);
        n_side.slab_miss = n_side.dir_zero && ((dlo > 0) || (dhi < 0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num_lo  <= {(dlo[DW-1] ? dlo_n[MW-1:0] : dlo[MW-1:0]), {rbsi_pkg::FRAC_W{1'b0}}};
            r_num_hi  <= {(dhi[DW-1] ? dhi_n[MW-1:0] : dhi[MW-1:0]), {rbsi_pkg::FRAC_W{1'b0}}};
            r_den     <= {dabs[FW-1:0], 1'b0};
            r_side[0] <= n_side;
        end
    end

    rbsi_div #(.NUM_W(NW), .DEN_W(EW)) u_div_lo (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num_lo),
        .i_den (r_den),
        .o_quo (quo_lo)
    );

    rbsi_div #(.NUM_W(NW), .DEN_W(EW)) u_div_hi (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_num_hi),
        .i_den (r_den),
        .o_quo (quo_hi)
    );

    // Flags travel beside the dividers.
    for (genvar k = 0; k < NW; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    logic signed [TW-1:0] t_a, t_b;
    rbsi_pkg::t_lane_res  r_res;

    always_comb begin
        t_a = r_side[NW].neg_lo ? -signed'({1'b0, quo_lo}) : signed'({1'b0, quo_lo});
        t_b = r_side[NW].neg_hi ? -signed'({1'b0, quo_hi}) : signed'({1'b0, quo_hi});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.limits    <= !r_side[NW].dir_zero;
            r_res.slab_miss <= r_side[NW].slab_miss;
            r_res.t_lo      <= (t_a > t_b) ? t_b : t_a;
            r_res.t_hi      <= (t_a > t_b) ? t_a : t_b;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/rbsi_merge.sv
// Merges the lane intervals into the hit flag and the saturated entry distance.
// Depends on rbsi_pkg.
module rbsi_merge #(
    parameter int LANES = rbsi_pkg::MAX_AXES
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  rbsi_pkg::t_lane_res                  i_res [LANES],
    output logic                                 o_hit,
    output logic signed [rbsi_pkg::FIELD_W-1:0]  o_t_entry
);

    localparam int TW = rbsi_pkg::T_W;
    localparam int FW = rbsi_pkg::FIELD_W;
    localparam logic signed [TW-1:0] T_MAX = TW'((64'sd1 <<< (FW - 1)) - 64'sd1);
    localparam logic signed [TW-1:0] T_MIN = -TW'(64'sd1 <<< (FW - 1));

    logic                 n_near_set, n_far_set, n_zmiss;
    logic signed [TW-1:0] n_near, n_far;
    logic                 r_near_set, r_far_set, r_zmiss;
    logic signed [TW-1:0] r_near, r_far;

    // Largest entry and smallest exit over the limiting axes.
    always_comb begin
        n_near_set = 1'b0;
        n_far_set  = 1'b0;
        n_zmiss    = 1'b0;
        n_near     = '0;
        n_far      = '0;
        for (int i = 0; i < LANES; i++) begin
            n_zmiss = n_zmiss | i_res[i].slab_miss;
            if (i_res[i].limits) begin
                if (!n_near_set || (i_res[i].t_lo > n_near)) begin
                    n_near = i_res[i].t_lo;
                end
                if (!n_far_set || (i_res[i].t_hi < n_far)) begin
                    n_far = i_res[i].t_hi;
                end
                n_near_set = 1'b1;
                n_far_set  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_near_set <= n_near_set;
            r_far_set  <= n_far_set;
            r_zmiss    <= n_zmiss;
            r_near     <= n_near;
            r_far      <= n_far;
        end
    end

    logic                 miss;
    logic signed [FW-1:0] t_sat;
    logic                 r_hit;
    logic signed [FW-1:0] r_t_entry;

    always_comb begin
        miss = r_zmiss
            || (r_near_set && r_far_set && (r_near > r_far))
            || (r_far_set && (r_far < 0));
        if (!r_near_set || (r_near < T_MIN)) begin
            t_sat = T_MIN[FW-1:0];
        end else if (r_near > T_MAX) begin
            t_sat = T_MAX[FW-1:0];
        end else begin
            t_sat = r_near[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit     <= !miss;
            r_t_entry <= miss ? '0 : t_sat;
        end
    end

    assign o_hit     = r_hit;
    assign o_t_entry = r_t_entry;

endmodule

### rtl/ray_box_slab_intersection.sv
// Ray versus axis-aligned box slab test, signed Q16.16, one lane per axis.
// Depends on rbsi_pkg, rbsi_lane, rbsi_merge and the assertion macro header.
//
// Use: present one item (ray origin, direction, box center, full size) on the
// input channel with i_valid; it is taken at a rising edge where o_stall is low.
// Each item yields exactly one result item (o_hit, o_t_entry) on the output
// channel, taken at a rising edge where o_valid is high and i_stall is low.
// From acceptance to o_valid an item passes one entry stage, 50 stages
// of the restoring dividers (one quotient bit of the 50-bit dividend each), one
// ordering stage, two merge stages and the output register. Throughput is
// one item per cycle while o_stall is low; each lane divider is fully pipelined.
// When the receiver stalls, the output register holds its item and a skid
// register catches the next finished item; only while the skid register is
// occupied does o_stall rise and the whole pipeline hold. Bubbles never
// cost acceptance on their own.
// Reset clears all valid flags, so the block comes out of reset empty and
// ready; data registers are not reset. o_t_entry is zero on a miss and is
// -2^31 when no axis limits the entry.
module ray_box_slab_intersection #(
    parameter int DIMS = rbsi_pkg::DIMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_origin_x,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_origin_y,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_origin_z,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_dir_x,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_dir_y,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_dir_z,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_center_x,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_center_y,
    input  logic signed [rbsi_pkg::FIELD_W-1:0]  i_center_z,
    input  logic        [rbsi_pkg::EXT_W-1:0]    i_extent_x,
    input  logic        [rbsi_pkg::EXT_W-1:0]    i_extent_y,
    input  logic        [rbsi_pkg::EXT_W-1:0]    i_extent_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic signed [rbsi_pkg::FIELD_W-1:0]  o_t_entry
);

    `include "ray_box_slab_intersection_macros.svh"

    localparam int FW    = rbsi_pkg::FIELD_W;
    localparam int LANES = (DIMS > rbsi_pkg::MAX_AXES) ? rbsi_pkg::MAX_AXES : DIMS;
    // Entry, divider stages, ordering, two merge stages.
    localparam int LAT   = rbsi_pkg::NUM_W + 4;

    logic signed [FW-1:0]             w_org [rbsi_pkg::MAX_AXES];
    logic signed [FW-1:0]             w_dir [rbsi_pkg::MAX_AXES];
    logic signed [FW-1:0]             w_cen [rbsi_pkg::MAX_AXES];
    logic        [rbsi_pkg::EXT_W-1:0] w_ext [rbsi_pkg::MAX_AXES];
    rbsi_pkg::t_lane_res              w_res [LANES];

    assign w_org = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign w_cen = '{i_center_x, i_center_y, i_center_z};
    assign w_ext = '{i_extent_x, i_extent_y, i_extent_z};

    logic [LAT-1:0]       r_vld;
    logic                 r_out_valid, r_skid_valid;
    logic                 r_out_hit, r_skid_hit;
    logic signed [FW-1:0] r_out_t, r_skid_t;
    logic                 take;
    logic                 skid_load;

    logic adv;
    logic pipe_hit;
    logic signed [FW-1:0] pipe_t;

    // The pipeline moves whenever the skid register is free.
    assign adv = !r_skid_valid;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        rbsi_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_origin (w_org[i]),
            .i_dir    (w_dir[i]),
            .i_center (w_cen[i]),
            .i_extent (w_ext[i]),
            .o_res    (w_res[i])
        );
    end

    rbsi_merge #(.LANES(LANES)) u_merge (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_res     (w_res),
        .o_hit     (pipe_hit),
        .o_t_entry (pipe_t)
    );

    assign take = r_out_valid && !i_stall;

    // A finished item arrives while the output register is held.
    assign skid_load = r_out_valid && i_stall && !r_skid_valid && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
            if (r_skid_valid) begin
                // Pipeline is frozen; drain the skid register first.
                if (take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || take) begin
                r_out_valid <= r_vld[LAT-1];
            end else if (r_vld[LAT-1]) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_hit <= r_skid_hit;
                r_out_t   <= r_skid_t;
            end
        end else if (!r_out_valid || take) begin
            r_out_hit <= pipe_hit;
            r_out_t   <= pipe_t;
        end else begin
            r_skid_hit <= pipe_hit;
            r_skid_t   <= pipe_t;
        end
    end

    assign o_stall   = r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_hit     = r_out_hit;
    assign o_t_entry = r_out_t;

    `RBSI_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `RBSI_ASSERT_IMP(a_miss_is_zero, i_clk, i_rst_n, r_out_valid && !r_out_hit, r_out_t == '0)
    `RBSI_ASSERT_NXT(a_skid_catches, i_clk, i_rst_n, skid_load, r_skid_valid)

endmodule
